>>> sv/wtach_pkg.sv
`default_nettype none

package wtach_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    localparam int TIME_W  = 32;
    localparam int EDGE_W  = 15;
    localparam int SCALE_W = 26;
    localparam int RPM_W   = 16;
    localparam int PROD_W  = SCALE_W + EDGE_W;
    localparam int STEP_W  = $clog2(PROD_W);

    localparam logic [EDGE_W-1:0]  EDGE_WRAP   = 15'd32767;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 26'd15000000;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(EDGE_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_RPM_SCALE = 3'd0;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_DONE
    } wtach_state_t;

    typedef struct packed {
        logic               start;
        logic               take;
        logic [SCALE_W-1:0] scale;
        logic [EDGE_W-1:0]  delta;
        logic [TIME_W-1:0]  elapsed;
    } wtach_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [RPM_W-1:0] rpm;
        logic             saturated;
        logic             zero_elapsed;
    } wtach_sts_t;

endpackage

`default_nettype wire

>>> sv/wtach_muldiv.sv
`default_nettype none

module wtach_muldiv (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wtach_pkg::wtach_req_t req,
    output wtach_pkg::wtach_sts_t  sts
);
    import wtach_pkg::*;

    wtach_state_t        state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [EDGE_W-1:0]   dig_reg, dig_next;
    logic [TIME_W-1:0]   div_reg, div_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [RPM_W-1:0]    quo_reg, quo_next;
    logic                sat_reg, sat_next;
    logic                zero_reg, zero_next;

    logic [TIME_W:0]     trial;
    logic [TIME_W:0]     trial_diff;
    logic                fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        dig_reg  <= dig_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
    end

    assign trial      = {rem_reg, acc_reg[PROD_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign fits       = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        dig_next   = dig_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sat_next   = sat_reg;
        zero_next  = zero_reg;

        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    sat_next = 1'b0;
                    quo_next = '0;
                    if (req.elapsed == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = U_DONE;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        acc_next   = '0;
                        rem_next   = '0;
                        dig_next   = req.delta;
                        div_next   = req.elapsed;
                        step_next  = MUL_LAST;
                        state_next = U_MUL;
                    end
                end
            end
            U_MUL:
            begin
                // shift-add, one multiplier bit per cycle, MSB first
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (dig_reg[EDGE_W-1] ? PROD_W'(req.scale) : '0);
                dig_next = {dig_reg[EDGE_W-2:0], 1'b0};
                if (step_reg == '0)
                begin
                    step_next  = DIV_LAST;
                    state_next = U_DIV;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            U_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (fits)
                begin
                    rem_next = trial_diff[TIME_W-1:0];
                end
                else
                begin
                    rem_next = trial[TIME_W-1:0];
                end
                acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                quo_next = {quo_reg[RPM_W-2:0], fits};
                if (fits && (step_reg >= STEP_W'(RPM_W)))
                begin
                    sat_next = 1'b1;
                end
                if (step_reg == '0)
                begin
                    state_next = U_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            U_DONE:
            begin
                if (req.take)
                begin
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    assign sts.busy         = (state_reg != U_IDLE);
    assign sts.done         = (state_reg == U_DONE);
    assign sts.saturated    = sat_reg && !zero_reg;
    assign sts.zero_elapsed = zero_reg;
    assign sts.rpm          = zero_reg ? '0 : (sat_reg ? '1 : quo_reg);

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == U_IDLE))
        else $error("start while unit busy");

    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        req.take |-> (state_reg == U_DONE))
        else $error("take without result");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.done && sts.saturated) |-> (sts.rpm == '1))
        else $error("saturated result not clipped");

    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.done && sts.zero_elapsed) |-> (sts.rpm == '0 && !sts.saturated))
        else $error("zero elapsed result not cleared");

    a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == U_MUL && step_reg == '0) |=> (state_reg == U_DIV))
        else $error("multiply did not hand over to divide");
`endif

endmodule

`default_nettype wire

>>> sv/windowed_tachometer_rpm.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   timestamp_us[31:0], edge_count[14:0]
// out      output     out_valid / out_ready rpm[15:0], saturated, zero_elapsed
// apb      slave      psel / penable        paddr[2:0], pwdata/prdata[31:0]
//
// One item at a time: a result is valid once the item is taken, run through
// 15 multiply steps plus 41 divide steps in the shared bit-serial unit and
// loaded into the output register; the unit skips both when the elapsed time
// is zero. The next item can be taken in the cycle after that load, not while
// one is still in the unit. rst_n clears the window ring and the ring pointer
// and sets rpm_scale to 15000000. A stalled result waits in the output
// register while the next item is already being worked on.
`default_nettype none

module windowed_tachometer_rpm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wtach_pkg::TIME_W-1:0]  timestamp_us,
    input  wire logic [wtach_pkg::EDGE_W-1:0]  edge_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [wtach_pkg::RPM_W-1:0]        rpm,
    output logic                               saturated,
    output logic                               zero_elapsed,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wtach_pkg::APB_AW-1:0]  paddr,
    input  wire logic [wtach_pkg::APB_DW-1:0]  pwdata,
    output logic [wtach_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);
    import wtach_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [TIME_W-1:0]  ring_time_reg  [WINDOW_DEPTH];
    logic [EDGE_W-1:0]  ring_count_reg [WINDOW_DEPTH];

    logic               out_valid_reg;
    logic [RPM_W-1:0]   rpm_reg;
    logic               sat_reg;
    logic               zero_reg;

    logic [PTR_W-1:0]   wr_idx;
    logic [PTR_W-1:0]   old_idx;
    logic               in_take;
    logic               out_load;
    logic               cfg_write;
    logic [EDGE_W:0]    cnt_diff;
    logic [EDGE_W:0]    cnt_wrap;
    logic [EDGE_W-1:0]  delta;
    logic [TIME_W-1:0]  elapsed;

    wtach_req_t         req;
    wtach_sts_t         sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_RPM_SCALE) ? APB_DW'(scale_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_write && (paddr == REG_RPM_SCALE))
        begin
            scale_reg <= pwdata[SCALE_W-1:0];
        end
    end

    assign in_ready = !sts.busy;
    assign in_take  = in_valid && in_ready;

    assign wr_idx  = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign old_idx = (wr_idx == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                ring_time_reg[i]  <= '0;
                ring_count_reg[i] <= '0;
            end
        end
        else if (in_take)
        begin
            ptr_reg                 <= wr_idx;
            ring_time_reg[wr_idx]   <= timestamp_us;
            ring_count_reg[wr_idx]  <= edge_count;
        end
    end

    // edge delta modulo the counter wrap
    assign cnt_diff = {1'b0, edge_count} - {1'b0, ring_count_reg[old_idx]};
    assign cnt_wrap = cnt_diff + {1'b0, EDGE_WRAP};

    always_comb
    begin
        if (cnt_diff[EDGE_W])
        begin
            delta = cnt_wrap[EDGE_W-1:0];
        end
        else if (cnt_diff[EDGE_W-1:0] == EDGE_WRAP)
        begin
            delta = '0;
        end
        else
        begin
            delta = cnt_diff[EDGE_W-1:0];
        end
    end

    assign elapsed = timestamp_us - ring_time_reg[old_idx];

    assign out_load    = sts.done && (!out_valid_reg || out_ready);
    assign req.start   = in_take;
    assign req.take    = out_load;
    assign req.scale   = scale_reg;
    assign req.delta   = delta;
    assign req.elapsed = elapsed;

    wtach_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .sts   (sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rpm_reg  <= sts.rpm;
            sat_reg  <= sts.saturated;
            zero_reg <= sts.zero_elapsed;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rpm          = rpm_reg;
    assign saturated    = sat_reg;
    assign zero_elapsed = zero_reg;

`ifndef NO_ASSERTIONS
    a_ring_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (ptr_reg == $past(wr_idx)))
        else $error("ring pointer did not advance");

    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (delta != EDGE_WRAP))
        else $error("edge delta out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(rpm_reg)))
        else $error("stalled item changed");
`endif

endmodule

`default_nettype wire
